// ===== rtl/core/i2c_master_bit_engine_core_assert.svh =====
// Assertion macros for the I2C master bit engine core.
`ifndef I2C_MASTER_BIT_ENGINE_CORE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define I2CM_ASSERT(lbl, c, r, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (r) (ante) |-> (cons)) \
    else $error("i2cm: assertion failed");
`define I2CM_ASSERT_NEXT(lbl, c, r, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (r) (ante) |=> (cons)) \
    else $error("i2cm: assertion failed");
`else
`define I2CM_ASSERT(lbl, c, r, ante, cons)
`define I2CM_ASSERT_NEXT(lbl, c, r, ante, cons)
`endif

`endif

// ===== rtl/core/i2cm_pkg.sv =====
package i2cm_pkg;

  typedef enum logic [4:0] {
    PH_IDLE, PH_S0, PH_S1, PH_S2, PH_S3, PH_P0, PH_P1, PH_P2, PH_P3,
    PH_WL, PH_WH, PH_RL, PH_RH, PH_AL, PH_AH, PH_WA0, PH_WA1, PH_POLL
  } phase_t;

  typedef enum logic [2:0] {
    CMD_TICK, CMD_START, CMD_STOP, CMD_WRITE, CMD_READ, CMD_WAIT_ACK
  } cmd_t;

  localparam logic [2:0] KIND_START    = 3'd1;
  localparam logic [2:0] KIND_STOP     = 3'd2;
  localparam logic [2:0] KIND_WRITE    = 3'd3;
  localparam logic [2:0] KIND_READ     = 3'd4;
  localparam logic [2:0] KIND_WAIT_ACK = 3'd5;

  typedef enum logic [1:0] {
    CFG_TICKS_PER_UNIT = 2'd0,
    CFG_ACK_POLL_LIMIT = 2'd1
  } cfg_idx_t;

  localparam logic [7:0] TPU_RESET        = 8'd1;
  localparam logic [7:0] POLL_LIMIT_RESET = 8'd250;
  localparam logic [3:0] BITS_PER_BYTE    = 4'd8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] write_byte;
    logic       send_ack;
    logic       sda_level;
  } item_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_ctl_t;

endpackage

// ===== rtl/core/i2cm_if.sv =====
interface i2cm_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] write_byte;
  logic       send_ack;
  logic       sda_level;
  modport source (output valid, kind, write_byte, send_ack, sda_level, input ready);
  modport sink   (input valid, kind, write_byte, send_ack, sda_level, output ready);
endinterface

interface i2cm_res_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_release;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;
  logic       ack_seen;
  logic       timed_out;
  modport source (output valid, scl_level, sda_release, busy_res, done_res, read_byte,
                  ack_seen, timed_out, input ready);
  modport sink   (input valid, scl_level, sda_release, busy_res, done_res, read_byte,
                  ack_seen, timed_out, output ready);
endinterface

interface i2cm_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/i2cm_front.sv =====
module i2cm_front import i2cm_pkg::*; (
  i2cm_cmd_if.sink cmd,
  input  logic     q_full,
  output q_ctl_t   q_ctl,
  output item_t    push_item
);

  cmd_t cmd_code;

  always_comb begin
    unique case (cmd.kind)
      KIND_START:    cmd_code = CMD_START;
      KIND_STOP:     cmd_code = CMD_STOP;
      KIND_WRITE:    cmd_code = CMD_WRITE;
      KIND_READ:     cmd_code = CMD_READ;
      KIND_WAIT_ACK: cmd_code = CMD_WAIT_ACK;
      default:       cmd_code = CMD_TICK;
    endcase
  end

  assign cmd.ready            = !q_full;
  assign q_ctl.push           = cmd.valid && !q_full;
  assign q_ctl.full           = q_full;
  assign push_item.cmd        = cmd_code;
  assign push_item.write_byte = cmd.write_byte;
  assign push_item.send_ack   = cmd.send_ack;
  assign push_item.sda_level  = cmd.sda_level;

endmodule

// ===== rtl/core/i2cm_queue.sv =====
module i2cm_queue import i2cm_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  q_ctl_t q_ctl,
  input  item_t  push_item,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output item_t  head_item
);

  item_t                  store [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_push;
  logic                   do_pop;

  assign full       = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = store[rd_ptr];
  assign do_push    = q_ctl.push && !q_ctl.full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      end
      count <= count + QUEUE_CNT_W'(do_push) - QUEUE_CNT_W'(do_pop);
    end
  end

endmodule

// ===== rtl/core/i2cm_back.sv =====
`include "i2c_master_bit_engine_core_assert.svh"

module i2cm_back import i2cm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  item_t       head_item,
  output logic        pop,
  i2cm_cfg_if.sink    cfg,
  i2cm_res_if.source  res
);

  logic [7:0] ticks_per_unit;
  logic [7:0] ack_poll_limit;

  phase_t     phase, phase_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic [7:0] unit_timer, unit_timer_next;
  logic [7:0] poll_count, poll_count_next;
  logic       scl_reg, scl_reg_next;
  logic       sda_reg, sda_reg_next;
  logic       ack_reg, ack_reg_next;
  logic       timeout_reg, timeout_reg_next;
  logic       ack_choice, ack_choice_next;
  logic [7:0] read_latch, read_latch_next;
  logic       done_next;

  logic       res_valid;
  phase_t     enter_ph;
  logic       do_enter;
  logic [7:0] unit;
  logic       unit_end;
  logic [3:0] bit_inc;

  assign cfg.ready = 1'b1;
  assign pop       = head_valid && (!res_valid || res.ready);
  assign unit      = (ticks_per_unit == 8'd0) ? 8'd1 : ticks_per_unit;
  assign unit_end  = ({1'b0, unit_timer} + 9'd1) >= {1'b0, unit};
  assign bit_inc   = bit_count + 4'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_unit <= TPU_RESET;
      ack_poll_limit <= POLL_LIMIT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg_idx_t'(cfg.index))
        CFG_TICKS_PER_UNIT: ticks_per_unit <= cfg.data;
        CFG_ACK_POLL_LIMIT: ack_poll_limit <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next       = phase;
    bit_count_next   = bit_count;
    shift_reg_next   = shift_reg;
    unit_timer_next  = unit_timer;
    poll_count_next  = poll_count;
    scl_reg_next     = scl_reg;
    sda_reg_next     = sda_reg;
    ack_reg_next     = ack_reg;
    timeout_reg_next = timeout_reg;
    ack_choice_next  = ack_choice;
    read_latch_next  = read_latch;
    done_next        = 1'b0;
    enter_ph         = PH_IDLE;
    do_enter         = 1'b0;

    if (phase == PH_IDLE) begin
      bit_count_next = 4'd0;
      unique case (head_item.cmd)
        CMD_START: begin
          enter_ph = PH_S0; do_enter = 1'b1;
        end
        CMD_STOP: begin
          enter_ph = PH_P0; do_enter = 1'b1;
        end
        CMD_WRITE: begin
          shift_reg_next = head_item.write_byte;
          enter_ph = PH_WL; do_enter = 1'b1;
        end
        CMD_READ: begin
          shift_reg_next  = 8'd0;
          ack_choice_next = head_item.send_ack;
          enter_ph = PH_RL; do_enter = 1'b1;
        end
        CMD_WAIT_ACK: begin
          ack_reg_next     = 1'b0;
          timeout_reg_next = 1'b0;
          poll_count_next  = 8'd0;
          enter_ph = PH_WA0; do_enter = 1'b1;
        end
        default: ;
      endcase
    end else if (phase == PH_POLL) begin
      if (!head_item.sda_level) begin
        ack_reg_next    = 1'b1;
        scl_reg_next    = 1'b0;
        phase_next      = PH_IDLE;
        unit_timer_next = 8'd0;
        done_next       = 1'b1;
      end else if (poll_count >= ack_poll_limit) begin
        timeout_reg_next = 1'b1;
        enter_ph = PH_P0; do_enter = 1'b1;
      end else begin
        poll_count_next = poll_count + 8'd1;
      end
    end else if (!unit_end) begin
      unit_timer_next = unit_timer + 8'd1;
    end else begin
      unique case (phase)
        PH_S0:  begin enter_ph = PH_S1;  do_enter = 1'b1; end
        PH_S1:  begin enter_ph = PH_S2;  do_enter = 1'b1; end
        PH_S2:  begin enter_ph = PH_S3;  do_enter = 1'b1; end
        PH_P0:  begin enter_ph = PH_P1;  do_enter = 1'b1; end
        PH_P1:  begin enter_ph = PH_P2;  do_enter = 1'b1; end
        PH_P2:  begin enter_ph = PH_P3;  do_enter = 1'b1; end
        PH_WL:  begin enter_ph = PH_WH;  do_enter = 1'b1; end
        PH_RL:  begin enter_ph = PH_RH;  do_enter = 1'b1; end
        PH_AL:  begin enter_ph = PH_AH;  do_enter = 1'b1; end
        PH_WA0: begin enter_ph = PH_WA1; do_enter = 1'b1; end
        PH_WA1: begin enter_ph = PH_POLL; do_enter = 1'b1; end
        PH_S3: begin
          scl_reg_next = 1'b0;
          phase_next = PH_IDLE; unit_timer_next = 8'd0; done_next = 1'b1;
        end
        PH_WH: begin
          shift_reg_next = {shift_reg[6:0], 1'b0};
          bit_count_next = bit_inc;
          if (bit_inc >= BITS_PER_BYTE) begin
            scl_reg_next = 1'b0;
            phase_next = PH_IDLE; unit_timer_next = 8'd0; done_next = 1'b1;
          end else begin
            enter_ph = PH_WL; do_enter = 1'b1;
          end
        end
        PH_RH: begin
          shift_reg_next = {shift_reg[6:0], head_item.sda_level};
          bit_count_next = bit_inc;
          enter_ph = (bit_inc >= BITS_PER_BYTE) ? PH_AL : PH_RL;
          do_enter = 1'b1;
        end
        PH_AH: begin
          read_latch_next = shift_reg;
          scl_reg_next = 1'b0;
          phase_next = PH_IDLE; unit_timer_next = 8'd0; done_next = 1'b1;
        end
        default: begin
          phase_next = PH_IDLE; unit_timer_next = 8'd0; done_next = 1'b1;
        end
      endcase
    end

    if (do_enter) begin
      phase_next      = enter_ph;
      unit_timer_next = 8'd0;
      unique case (enter_ph)
        PH_S0:  begin scl_reg_next = 1'b1; sda_reg_next = 1'b1; end
        PH_S2:  sda_reg_next = 1'b0;
        PH_P0:  begin scl_reg_next = 1'b0; sda_reg_next = 1'b0; end
        PH_P2:  begin scl_reg_next = 1'b1; sda_reg_next = 1'b1; end
        PH_WL:  begin scl_reg_next = 1'b0; sda_reg_next = shift_reg_next[7]; end
        PH_RL:  begin scl_reg_next = 1'b0; sda_reg_next = 1'b1; end
        PH_AL:  begin scl_reg_next = 1'b0; sda_reg_next = !ack_choice_next; end
        PH_WA0: sda_reg_next = 1'b1;
        PH_WH, PH_RH, PH_AH, PH_WA1: scl_reg_next = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bit_count   <= 4'd0;
      shift_reg   <= 8'd0;
      unit_timer  <= 8'd0;
      poll_count  <= 8'd0;
      scl_reg     <= 1'b1;
      sda_reg     <= 1'b1;
      ack_reg     <= 1'b0;
      timeout_reg <= 1'b0;
      ack_choice  <= 1'b0;
      read_latch  <= 8'd0;
    end else if (pop) begin
      phase       <= phase_next;
      bit_count   <= bit_count_next;
      shift_reg   <= shift_reg_next;
      unit_timer  <= unit_timer_next;
      poll_count  <= poll_count_next;
      scl_reg     <= scl_reg_next;
      sda_reg     <= sda_reg_next;
      ack_reg     <= ack_reg_next;
      timeout_reg <= timeout_reg_next;
      ack_choice  <= ack_choice_next;
      read_latch  <= read_latch_next;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res.scl_level   <= scl_reg_next;
      res.sda_release <= sda_reg_next;
      res.busy_res    <= (phase_next != PH_IDLE);
      res.done_res    <= done_next;
      res.read_byte   <= read_latch_next;
      res.ack_seen    <= ack_reg_next;
      res.timed_out   <= timeout_reg_next;
    end
  end

  assign res.valid = res_valid;

  `I2CM_ASSERT_NEXT(a_done_not_busy, clk, rst, pop && done_next, res.valid && !res.busy_res)
  `I2CM_ASSERT(a_flags_exclusive, clk, rst, res.valid, !(res.ack_seen && res.timed_out))
  `I2CM_ASSERT(a_poll_scl_high, clk, rst, phase == PH_POLL, scl_reg)
  `I2CM_ASSERT(a_bit_count_range, clk, rst, phase != PH_IDLE, bit_count <= BITS_PER_BYTE)

endmodule

// ===== rtl/core/i2c_master_bit_engine_core.sv =====
// channel | dir | handshake    | word
// cmd     | in  | valid/ready  | kind, write_byte, send_ack, sda_level (one tick)
// res     | out | valid/ready  | scl_level, sda_release, busy_res, done_res,
//         |     |              | read_byte, ack_seen, timed_out
// cfg     | in  | valid/ready  | index (0 ticks_per_unit, 1 ack_poll_limit), data
//
// One tick word accepted per clock while the queue is not full; each gives one result word
// in the cycle after it leaves the two-entry queue, where the result word is registered.
// The engine steps once per popped tick word; its phase changes are set by the unit timer compare.
// rst is synchronous: line released, engine idle, queue empty, cfg at defaults.
// A stalled res backs up into the queue; cmd.ready drops only when it is full.
module i2c_master_bit_engine_core import i2cm_pkg::*; (
  input logic         clk,
  input logic         rst,
  i2cm_cmd_if.sink    cmd,
  i2cm_res_if.source  res,
  i2cm_cfg_if.sink    cfg
);

  q_ctl_t q_ctl;
  item_t  push_item;
  item_t  head_item;
  logic   q_full;
  logic   head_valid;
  logic   pop;

  i2cm_front u_front (
    .cmd       (cmd),
    .q_full    (q_full),
    .q_ctl     (q_ctl),
    .push_item (push_item)
  );

  i2cm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .q_ctl      (q_ctl),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  i2cm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .cfg        (cfg),
    .res        (res)
  );

endmodule

// ===== sim/i2c_master_bit_engine_core_tb.sv =====
module i2c_master_bit_engine_core_tb;
  import i2cm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [2:0] KIND_SPARE_A = 3'd6;
  localparam logic [2:0] KIND_SPARE_B = 3'd7;

  typedef struct packed {
    logic       scl;
    logic       sda_rel;
    logic       busy;
    logic       done;
    logic [7:0] rbyte;
    logic       ack;
    logic       tmo;
  } line_word_t;

  logic clk;
  logic rst;

  i2cm_cmd_if cmd_ch();
  i2cm_res_if res_ch();
  i2cm_cfg_if cfg_ch();

  i2c_master_bit_engine_core dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch),
    .cfg(cfg_ch)
  );

  // engine model state
  phase_t     ph;
  logic [3:0] bitn;
  logic [7:0] shreg;
  logic [7:0] utmr;
  logic [7:0] polls;
  logic       scl_q;
  logic       sda_q;
  logic       ack_q;
  logic       tmo_q;
  logic       ack_sel;
  logic [7:0] rd_latch;
  logic       done_q;
  logic [7:0] cfg_tpu;
  logic [7:0] cfg_poll_lim;

  line_word_t expected_lines[$];
  int mismatches;
  int cyc;
  int ticks_sent;
  int src_idle;
  int snk_idle;
  int hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic void go(phase_t p);
    ph = p;
    utmr = 8'd0;
    case (p)
      PH_S0: begin
        scl_q = 1'b1;
        sda_q = 1'b1;
      end
      PH_S2: sda_q = 1'b0;
      PH_P0: begin
        scl_q = 1'b0;
        sda_q = 1'b0;
      end
      PH_P2: begin
        scl_q = 1'b1;
        sda_q = 1'b1;
      end
      PH_WL: begin
        scl_q = 1'b0;
        sda_q = shreg[7];
      end
      PH_RL: begin
        scl_q = 1'b0;
        sda_q = 1'b1;
      end
      PH_AL: begin
        scl_q = 1'b0;
        sda_q = ~ack_sel;
      end
      PH_WA0: sda_q = 1'b1;
      PH_WH, PH_RH, PH_AH, PH_WA1: scl_q = 1'b1;
      default: ;
    endcase
  endfunction

  function automatic void end_cmd();
    ph = PH_IDLE;
    utmr = 8'd0;
    done_q = 1'b1;
  endfunction

  function automatic line_word_t engine_tick(logic [2:0] k, logic [7:0] b, logic a,
                                             logic s);
    int unit_len;
    line_word_t r;
    unit_len = (cfg_tpu == 8'd0) ? 1 : int'(cfg_tpu);
    done_q = 1'b0;
    if (ph == PH_IDLE) begin
      bitn = 4'd0;
      case (k)
        CMD_START: go(PH_S0);
        CMD_STOP: go(PH_P0);
        CMD_WRITE: begin
          shreg = b;
          go(PH_WL);
        end
        CMD_READ: begin
          shreg = 8'd0;
          ack_sel = a;
          go(PH_RL);
        end
        CMD_WAIT_ACK: begin
          ack_q = 1'b0;
          tmo_q = 1'b0;
          polls = 8'd0;
          go(PH_WA0);
        end
        default: ;
      endcase
    end else if (ph == PH_POLL) begin
      if (!s) begin
        ack_q = 1'b1;
        scl_q = 1'b0;
        end_cmd();
      end else if (polls >= cfg_poll_lim) begin
        tmo_q = 1'b1;
        go(PH_P0);
      end else begin
        polls = polls + 8'd1;
      end
    end else if (int'(utmr) + 1 < unit_len) begin
      utmr = utmr + 8'd1;
    end else begin
      case (ph)
        PH_S0: go(PH_S1);
        PH_S1: go(PH_S2);
        PH_S2: go(PH_S3);
        PH_S3: begin
          scl_q = 1'b0;
          end_cmd();
        end
        PH_P0: go(PH_P1);
        PH_P1: go(PH_P2);
        PH_P2: go(PH_P3);
        PH_P3: end_cmd();
        PH_WL: go(PH_WH);
        PH_WH: begin
          shreg = {shreg[6:0], 1'b0};
          bitn = bitn + 4'd1;
          if (bitn >= BITS_PER_BYTE) begin
            scl_q = 1'b0;
            end_cmd();
          end else begin
            go(PH_WL);
          end
        end
        PH_RL: go(PH_RH);
        PH_RH: begin
          shreg = {shreg[6:0], s};
          bitn = bitn + 4'd1;
          if (bitn >= BITS_PER_BYTE) go(PH_AL);
          else go(PH_RL);
        end
        PH_AL: go(PH_AH);
        PH_AH: begin
          rd_latch = shreg;
          scl_q = 1'b0;
          end_cmd();
        end
        PH_WA0: go(PH_WA1);
        PH_WA1: go(PH_POLL);
        default: end_cmd();
      endcase
    end
    r.scl = scl_q;
    r.sda_rel = sda_q;
    r.busy = (ph != PH_IDLE);
    r.done = done_q;
    r.rbyte = rd_latch;
    r.ack = ack_q;
    r.tmo = tmo_q;
    return r;
  endfunction

  task automatic send_tick(input logic [2:0] k, input logic [7:0] b, input logic a,
                           input logic s);
    while ($urandom_range(99) < src_idle) begin
      cmd_ch.valid = 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid = 1'b1;
    cmd_ch.kind = k;
    cmd_ch.write_byte = b;
    cmd_ch.send_ack = a;
    cmd_ch.sda_level = s;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    expected_lines.push_back(engine_tick(k, b, a, s));
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic drain_engine();
    while (ph != PH_IDLE) send_tick(CMD_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] val);
    drain_engine();
    cmd_ch.valid = 1'b0;
    while (expected_lines.size() != 0) @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == CFG_TICKS_PER_UNIT) cfg_tpu = val;
    else cfg_poll_lim = val;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // b doubles as the byte the slave returns on a read
  task automatic do_cmd(input logic [2:0] k, input logic [7:0] b, input logic a,
                        input int high_polls, input bit noisy);
    int polled;
    logic [2:0] nk;
    logic s;
    polled = 0;
    drain_engine();
    send_tick(k, b, a, 1'($urandom));
    while (ph != PH_IDLE) begin
      nk = (noisy && $urandom_range(3) == 0) ? 3'($urandom_range(7)) : CMD_TICK;
      if (ph == PH_POLL) begin
        s = (polled >= high_polls) ? 1'b0 : 1'b1;
        polled++;
      end else if (ph == PH_RL || ph == PH_RH) begin
        s = b[7 - bitn];
      end else begin
        s = 1'($urandom);
      end
      send_tick(nk, 8'($urandom), 1'($urandom), s);
    end
  endtask

  task automatic idle_gap();
    logic [2:0] nk;
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(2))
        0: nk = CMD_TICK;
        1: nk = KIND_SPARE_A;
        default: nk = KIND_SPARE_B;
      endcase
      send_tick(nk, 8'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  task automatic test_bus_frame();
    do_cmd(CMD_START, 8'h00, 1'b0, 0, 1'b0);
    do_cmd(CMD_WRITE, 8'h00, 1'b0, 0, 1'b0);
    do_cmd(CMD_WAIT_ACK, 8'h00, 1'b0, 0, 1'b0);
    do_cmd(CMD_WRITE, 8'hFF, 1'b1, 0, 1'b0);
    do_cmd(CMD_WAIT_ACK, 8'hFF, 1'b1, 2, 1'b0);
    do_cmd(CMD_READ, 8'hA5, 1'b1, 0, 1'b0);
    do_cmd(CMD_READ, 8'h5A, 1'b0, 0, 1'b0);
    do_cmd(CMD_STOP, 8'h00, 1'b0, 0, 1'b0);
  endtask

  task automatic test_spare_kinds();
    send_tick(KIND_SPARE_A, 8'hFF, 1'b1, 1'b0);
    send_tick(KIND_SPARE_B, 8'h00, 1'b0, 1'b1);
    send_tick(CMD_TICK, 8'hFF, 1'b1, 1'b1);
  endtask

  // commands offered while a start runs are dropped
  task automatic test_busy_commands();
    drain_engine();
    send_tick(CMD_START, 8'h00, 1'b0, 1'b1);
    send_tick(CMD_STOP, 8'h00, 1'b0, 1'b1);
    send_tick(CMD_WRITE, 8'hC3, 1'b0, 1'b1);
    send_tick(CMD_READ, 8'h00, 1'b1, 1'b1);
    send_tick(CMD_WAIT_ACK, 8'h00, 1'b0, 1'b0);
    send_tick(CMD_START, 8'h00, 1'b0, 1'b0);
    drain_engine();
    // a write with random commands offered on its ticks
    do_cmd(CMD_WRITE, 8'h81, 1'b0, 0, 1'b1);
  endtask

  task automatic test_poll_limit();
    write_reg(CFG_ACK_POLL_LIMIT, 8'd0);
    do_cmd(CMD_WAIT_ACK, 8'h00, 1'b0, 1, 1'b0);
    do_cmd(CMD_WAIT_ACK, 8'h00, 1'b0, 0, 1'b0);
    write_reg(CFG_ACK_POLL_LIMIT, 8'd3);
    do_cmd(CMD_WAIT_ACK, 8'h00, 1'b0, 3, 1'b0);
    do_cmd(CMD_WAIT_ACK, 8'h00, 1'b0, 4, 1'b0);
    write_reg(CFG_ACK_POLL_LIMIT, 8'd255);
    do_cmd(CMD_WAIT_ACK, 8'h00, 1'b0, 256, 1'b0);
    write_reg(CFG_ACK_POLL_LIMIT, POLL_LIMIT_RESET);
  endtask

  task automatic test_unit_len();
    write_reg(CFG_TICKS_PER_UNIT, 8'd0);
    do_cmd(CMD_START, 8'h00, 1'b0, 0, 1'b0);
    write_reg(CFG_TICKS_PER_UNIT, 8'd2);
    do_cmd(CMD_WRITE, 8'h96, 1'b0, 0, 1'b1);
    do_cmd(CMD_READ, 8'h69, 1'b1, 0, 1'b0);
    write_reg(CFG_TICKS_PER_UNIT, 8'd255);
    do_cmd(CMD_WAIT_ACK, 8'h00, 1'b0, 0, 1'b0);
    write_reg(CFG_TICKS_PER_UNIT, TPU_RESET);
  endtask

  task automatic test_backpressure();
    hold_left = 80;
    do_cmd(CMD_WRITE, 8'($urandom), 1'b0, 0, 1'b0);
    do_cmd(CMD_READ, 8'($urandom), 1'b1, 0, 1'b0);
  endtask

  task automatic random_transaction();
    int n;
    int i;
    n = $urandom_range(1, 3);
    do_cmd(CMD_START, 8'($urandom), 1'($urandom), 0, 1'($urandom));
    do_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), 0, 1'($urandom));
    do_cmd(CMD_WAIT_ACK, 8'($urandom), 1'($urandom),
           $urandom_range(0, int'(cfg_poll_lim) + 1), 1'($urandom));
    for (i = 0; i < n; i++) begin
      if ($urandom_range(1)) begin
        do_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), 0, 1'($urandom));
        do_cmd(CMD_WAIT_ACK, 8'($urandom), 1'($urandom),
               $urandom_range(0, int'(cfg_poll_lim) + 1), 1'($urandom));
      end else begin
        do_cmd(CMD_READ, 8'($urandom), (i != n - 1), 0, 1'($urandom));
      end
      idle_gap();
    end
    do_cmd(CMD_STOP, 8'($urandom), 1'($urandom), 0, 1'($urandom));
  endtask

  task automatic test_random_traffic(input int src_pct, input int snk_pct,
                                     input int n_ticks);
    int stop_at;
    write_reg(CFG_TICKS_PER_UNIT, 8'($urandom_range(0, 3)));
    write_reg(CFG_ACK_POLL_LIMIT, 8'($urandom_range(0, 6)));
    src_idle = src_pct;
    snk_idle = snk_pct;
    stop_at = ticks_sent + n_ticks;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(4) != 0) begin
        random_transaction();
      end else begin
        // stray single commands: broken sequences
        do_cmd(3'($urandom_range(1, 5)), 8'($urandom), 1'($urandom),
               $urandom_range(0, int'(cfg_poll_lim) + 1), 1'($urandom));
      end
      idle_gap();
    end
  endtask

  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_ch.ready = 1'b0;
        hold_left--;
      end else begin
        res_ch.ready = ($urandom_range(99) >= snk_idle);
      end
    end
  end

  always @(posedge clk) begin
    line_word_t got;
    line_word_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.scl = res_ch.scl_level;
      got.sda_rel = res_ch.sda_release;
      got.busy = res_ch.busy_res;
      got.done = res_ch.done_res;
      got.rbyte = res_ch.read_byte;
      got.ack = res_ch.ack_seen;
      got.tmo = res_ch.timed_out;
      if (expected_lines.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("cycle %0d: result word with none expected: %h", cyc, got);
      end else begin
        want = expected_lines.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("cycle %0d: scl/sda/busy/done/rd/ack/tmo", cyc);
            $display("  expected %b %b %b %b %h %b %b", want.scl, want.sda_rel,
                     want.busy, want.done, want.rbyte, want.ack, want.tmo);
            $display("  actual   %b %b %b %b %h %b %b", got.scl, got.sda_rel,
                     got.busy, got.done, got.rbyte, got.ack, got.tmo);
          end
        end
      end
    end
  end

  initial begin
    mismatches = 0;
    cyc = 0;
    ticks_sent = 0;
    src_idle = 18;
    snk_idle = 46;
    hold_left = 0;
    ph = PH_IDLE;
    bitn = 4'd0;
    shreg = 8'd0;
    utmr = 8'd0;
    polls = 8'd0;
    scl_q = 1'b1;
    sda_q = 1'b1;
    ack_q = 1'b0;
    tmo_q = 1'b0;
    ack_sel = 1'b0;
    rd_latch = 8'd0;
    done_q = 1'b0;
    cfg_tpu = TPU_RESET;
    cfg_poll_lim = POLL_LIMIT_RESET;
    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.kind = CMD_TICK;
    cmd_ch.write_byte = 8'd0;
    cmd_ch.send_ack = 1'b0;
    cmd_ch.sda_level = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_TICKS_PER_UNIT;
    cfg_ch.data = 8'd0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_bus_frame();
    test_spare_kinds();
    test_busy_commands();
    test_poll_limit();
    test_unit_len();
    test_backpressure();
    test_random_traffic(18, 46, 250);
    test_random_traffic(46, 18, 250);
    test_random_traffic(0, 0, 250);

    cmd_ch.valid = 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
